[hdl/b32d_pkg.sv]
// ----------------------------------------------------------------------------
// b32d_pkg
// shared types, constants and helper functions of the base32 text decoder
// ----------------------------------------------------------------------------
package b32d_pkg;

  localparam int unsigned CharW      = 8;
  localparam int unsigned SymW       = 5;
  localparam int unsigned GroupW     = 40;
  localparam int unsigned PosW       = 3;
  localparam int unsigned NBytesW    = 3;
  localparam int unsigned GroupFifoDepth = 4;

  localparam logic [CharW-1:0] ChrUpperA = 8'h41;  // 'A'
  localparam logic [CharW-1:0] ChrUpperZ = 8'h5A;  // 'Z'
  localparam logic [CharW-1:0] ChrDigit2 = 8'h32;  // '2'
  localparam logic [CharW-1:0] ChrDigit7 = 8'h37;  // '7'
  localparam logic [SymW-1:0]  DigitBase = 5'd26;

  localparam logic [PosW-1:0]  LastPos   = 3'd7;

  // one finished group handed from front to back
  typedef struct packed {
    logic [GroupW-1:0]  acc;
    logic [NBytesW-1:0] nbytes;
    logic               fin;
  } group_t;

  // symbol value of a character, zero for anything outside the alphabet
  function automatic logic [SymW-1:0] sym_value(input logic [CharW-1:0] c);
    logic [CharW-1:0] diff;
    diff = '0;
    if (c >= ChrUpperA && c <= ChrUpperZ) begin
      diff = c - ChrUpperA;
      return diff[SymW-1:0];
    end else if (c >= ChrDigit2 && c <= ChrDigit7) begin
      diff = c - ChrDigit2;
      return diff[SymW-1:0] + DigitBase;
    end
    return '0;
  endfunction

  // whole bytes in a group of (pos + 1) characters
  function automatic logic [NBytesW-1:0] group_bytes(input logic [PosW-1:0] pos);
    logic [NBytesW-1:0] nb;
    unique case (pos)
      3'd0:    nb = 3'd0;
      3'd1:    nb = 3'd1;
      3'd2:    nb = 3'd1;
      3'd3:    nb = 3'd2;
      3'd4:    nb = 3'd3;
      3'd5:    nb = 3'd3;
      3'd6:    nb = 3'd4;
      3'd7:    nb = 3'd5;
      default: nb = 3'd0;
    endcase
    return nb;
  endfunction

  // byte k of a group, most significant first
  function automatic logic [CharW-1:0] group_byte(input logic [GroupW-1:0] acc,
                                                  input logic [NBytesW-1:0] k);
    logic [CharW-1:0] b;
    unique case (k)
      3'd0:    b = acc[39:32];
      3'd1:    b = acc[31:24];
      3'd2:    b = acc[23:16];
      3'd3:    b = acc[15:8];
      3'd4:    b = acc[7:0];
      default: b = '0;
    endcase
    return b;
  endfunction

endpackage

[hdl/base32_text_decoder_unit.sv]
// ----------------------------------------------------------------------------
// base32_text_decoder_unit
// streaming base32 text decoder, one character in, bytes out
// ----------------------------------------------------------------------------
// characters 'A'-'Z' and '2'-'7' carry 5-bit values 0-31, any other code
// takes a position and counts as value 0. eight characters, or a character
// with text_end_i set, close a group of up to 40 bits, which leaves as
// count*5/8 bytes, most significant first; leftover bits are dropped, so a
// one-character final run gives no bytes. a character is taken every cycle
// while full is low; a closed group goes into a small group queue and the
// back end sends one byte per cycle from it into the output register while
// that register is empty or being popped. the first byte of a group passes
// through the group queue and then the output register before it can be
// popped. a group never gives more bytes than it took characters, so the
// back end keeps up with a character every cycle and full rises only when
// the result side stalls long enough for the group queue to fill.
module base32_text_decoder_unit #(
  parameter int unsigned GroupFifoDepth = b32d_pkg::GroupFifoDepth
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // character side
  input  logic                       push,
  output logic                       full,
  input  logic [b32d_pkg::CharW-1:0] char_code_i,
  input  logic                       text_end_i,
  // byte side
  output logic                       empty,
  input  logic                       pop,
  output logic [b32d_pkg::CharW-1:0] data_byte_o,
  output logic                       run_last_o,
  output logic                       from_final_char_o
);
  import b32d_pkg::*;

  group_t grp_in, grp_out;
  logic   grp_push, grp_pop, grp_full, grp_empty;
  logic   take;

  // a character transfer happens whenever the group queue has room
  assign full = grp_full;
  assign take = push && !grp_full;

  // front: symbol lookup and group packing
  b32d_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .take_i      (take),
    .char_code_i (char_code_i),
    .text_end_i  (text_end_i),
    .grp_push_o  (grp_push),
    .grp_o       (grp_in)
  );

  // queue of closed groups, lets front and back stall independently
  b32d_group_fifo #(
    .Depth (GroupFifoDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (grp_push),
    .data_i  (grp_in),
    .pop_i   (grp_pop),
    .data_o  (grp_out),
    .full_o  (grp_full),
    .empty_o (grp_empty)
  );

  // back: byte emission with a registered output stage
  b32d_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .grp_i             (grp_out),
    .grp_empty_i       (grp_empty),
    .grp_pop_o         (grp_pop),
    .pop_i             (pop),
    .empty_o           (empty),
    .data_byte_o       (data_byte_o),
    .run_last_o        (run_last_o),
    .from_final_char_o (from_final_char_o)
  );

endmodule

[hdl/b32d_front.sv]
// ----------------------------------------------------------------------------
// b32d_front
// takes characters, packs symbol values into the group, closes groups
// ----------------------------------------------------------------------------
module b32d_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          take_i,
  input  logic [b32d_pkg::CharW-1:0]    char_code_i,
  input  logic                          text_end_i,
  output logic                          grp_push_o,
  output b32d_pkg::group_t              grp_o
);
  import b32d_pkg::*;

  logic [GroupW-1:0] acc_q, acc_d;
  logic [PosW-1:0]   pos_q, pos_d;
  logic [GroupW-1:0] acc_new;
  logic [5:0]        shift;
  logic              close;

  // slot of this character: bits 39-5*pos down to 35-5*pos
  assign shift   = 6'd35 - (6'(pos_q) * 6'd5);
  assign acc_new = acc_q | (GroupW'(sym_value(char_code_i)) << shift);
  assign close   = (pos_q == LastPos) || text_end_i;

  assign grp_o.acc    = acc_new;
  assign grp_o.nbytes = group_bytes(pos_q);
  assign grp_o.fin    = text_end_i;
  // groups too short for a byte are dropped here
  assign grp_push_o   = take_i && close && (group_bytes(pos_q) != '0);

  always_comb begin
    acc_d = acc_q;
    pos_d = pos_q;
    if (take_i) begin
      if (close) begin
        acc_d = '0;
        pos_d = '0;
      end else begin
        acc_d = acc_new;
        pos_d = pos_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
      pos_q <= '0;
    end else begin
      acc_q <= acc_d;
      pos_q <= pos_d;
    end
  end

endmodule

[hdl/b32d_group_fifo.sv]
// ----------------------------------------------------------------------------
// b32d_group_fifo
// short queue of closed groups between front and back
// ----------------------------------------------------------------------------
module b32d_group_fifo #(
  parameter int unsigned Depth = b32d_pkg::GroupFifoDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  b32d_pkg::group_t data_i,
  input  logic             pop_i,
  output b32d_pkg::group_t data_o,
  output logic             full_o,
  output logic             empty_o
);
  import b32d_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrMax = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntMax = CntW'(Depth);

  group_t            mem_q [Depth];
  logic [PtrW-1:0]   wr_q, rd_q;
  logic [CntW-1:0]   cnt_q;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == CntMax);
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PtrMax) ? '0 : wr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == PtrMax) ? '0 : rd_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

[hdl/b32d_back.sv]
// ----------------------------------------------------------------------------
// b32d_back
// walks each group a byte per cycle to the output reg while free or popped
// ----------------------------------------------------------------------------
module b32d_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  b32d_pkg::group_t           grp_i,
  input  logic                       grp_empty_i,
  output logic                       grp_pop_o,
  input  logic                       pop_i,
  output logic                       empty_o,
  output logic [b32d_pkg::CharW-1:0] data_byte_o,
  output logic                       run_last_o,
  output logic                       from_final_char_o
);
  import b32d_pkg::*;

  logic [NBytesW-1:0] k_q;
  logic               out_valid_q;
  logic [CharW-1:0]   byte_q;
  logic               last_q, fin_q;
  logic               load, step, is_last;

  assign load      = !out_valid_q || pop_i;
  assign step      = load && !grp_empty_i;
  assign is_last   = (k_q + 3'd1) == grp_i.nbytes;
  assign grp_pop_o = step && is_last;

  assign empty_o           = !out_valid_q;
  assign data_byte_o       = byte_q;
  assign run_last_o        = last_q;
  assign from_final_char_o = fin_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      k_q         <= '0;
    end else begin
      if (load) begin
        out_valid_q <= !grp_empty_i;
      end
      if (step) begin
        k_q <= is_last ? '0 : k_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      byte_q <= group_byte(grp_i.acc, k_q);
      last_q <= is_last;
      fin_q  <= grp_i.fin;
    end
  end

endmodule
